FILE: rtl/cursor_linked_list_engine_macros.svh
// Assertion helpers for the linked list engine
`ifndef CURSOR_LINKED_LIST_ENGINE_MACROS_SVH
`define CURSOR_LINKED_LIST_ENGINE_MACROS_SVH
// assert that a implies b in the same cycle
`define CLL_ASSERT_IMPL(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// assert that a implies b in the next cycle
`define CLL_ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`endif

FILE: rtl/clle_pkg.sv
package clle_pkg;
   localparam int CAPACITY_DEF   = 256;
   localparam int ELEM_WIDTH_DEF = 32;

   typedef enum logic [4:0] {
      FN_QUERY = 5'd0, FN_CLEAR = 5'd1, FN_FRONT = 5'd2, FN_BACK = 5'd3,
      FN_NEXT = 5'd4, FN_PREV = 5'd5, FN_INS_AFTER = 5'd6, FN_INS_BEFORE = 5'd7,
      FN_SET_AFTER = 5'd8, FN_SET_BEFORE = 5'd9, FN_ERASE_AFTER = 5'd10,
      FN_ERASE_BEFORE = 5'd11, FN_FIND_NEXT = 5'd12, FN_FIND_PREV = 5'd13,
      FN_PEEK_NEXT = 5'd14, FN_PEEK_PREV = 5'd15, FN_READ_FRONT = 5'd16,
      FN_READ_BACK = 5'd17
   } func_type;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_EMPTY = 3'd1;
   localparam logic [2:0] ST_AT_BACK = 3'd2;
   localparam logic [2:0] ST_AT_FRONT = 3'd3;
   localparam logic [2:0] ST_FULL = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND = 3'd5;

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_READ, S_EXEC, S_WALK
   } state_type;

   typedef struct packed {
      logic [4:0]         func;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] element;
      logic [8:0]         cursor_position;
      logic [8:0]         list_length;
      logic [2:0]         status;
   } rsp_type;
endpackage

FILE: rtl/clle_node_mem.sv
module clle_node_mem
   import clle_pkg::*;
#(
   parameter int AW = 9,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);
   logic [DW-1:0] mem [(1<<AW)];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

FILE: rtl/cursor_linked_list_engine.sv
// Cursor linked list engine.
// Input: req_func/req_value as req_data, taken when start is high and busy low.
// Output: one result per transaction, shown for one cycle with rsp_valid high;
// the receiver cannot stall, so results are never held.
// Nodes live in synchronous memories (value, next, prev, free stack), one
// registered read port each. Next and prev links may be written together.
// Steps per transaction, from the accepting edge: query, cursor moves,
// peeks and overwrites read, then respond; read front/back, inserts and
// erases read, then do a value read or link write-back, then respond;
// find reads and compares each node passed in turn, and responds on a
// match or when it runs off the list end. The next transaction is taken at
// the edge that ends the result cycle, so transactions never overlap.
// Reset (and clear) starts a pass that rebuilds the free stack and the
// sentinel links, one entry per cycle; busy is high during it, and a clear
// answers when the pass ends.
// Index CAPACITY is the front sentinel, CAPACITY+1 the back sentinel.
module cursor_linked_list_engine
   import clle_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
`include "cursor_linked_list_engine_macros.svh"
   localparam int NW = $clog2(CAPACITY + 2);
   localparam int FW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [NW-1:0] FRONT = NW'(CAPACITY);
   localparam logic [NW-1:0] BACK  = NW'(CAPACITY + 1);

   state_type state_ff, state_in;
   logic [4:0] func_ff, func_in;
   logic [ELEM_WIDTH-1:0] val_ff, val_in;
   logic [NW-1:0] bef_ff, bef_in, aft_ff, aft_in, new_ff, new_in;
   logic [CW-1:0] cur_ff, cur_in, cnt_ff, cnt_in, free_ff, free_in;
   logic [NW-1:0] init_ff, init_in;
   logic [2:0] step_ff, step_in;
   logic [31:0] elem_ff, elem_in;
   logic [2:0] st_ff, st_in;
   logic done;

   // memories
   logic           v_we;  logic [NW-1:0] v_wa, v_ra; logic [ELEM_WIDTH-1:0] v_wd, v_rd;
   logic           n_we;  logic [NW-1:0] n_wa, n_ra, n_wd, n_rd;
   logic           p_we;  logic [NW-1:0] p_wa, p_ra, p_wd, p_rd;
   logic           f_we;  logic [FW-1:0] f_wa, f_ra; logic [NW-1:0] f_wd, f_rd;

   clle_node_mem #(.AW(NW), .DW(ELEM_WIDTH)) u_val (.clock, .we(v_we), .waddr(v_wa),
      .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
   clle_node_mem #(.AW(NW), .DW(NW)) u_next (.clock, .we(n_we), .waddr(n_wa),
      .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));
   clle_node_mem #(.AW(NW), .DW(NW)) u_prev (.clock, .we(p_we), .waddr(p_wa),
      .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
   clle_node_mem #(.AW(FW), .DW(NW)) u_free (.clock, .we(f_we), .waddr(f_wa),
      .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

   logic at_back, at_front;
   logic [ELEM_WIDTH-1:0] v_ext;
   assign at_back  = cur_ff >= cnt_ff;
   assign at_front = cur_ff == '0;
   assign v_ext = ELEM_WIDTH'({{32{req_data.value[31]}}, req_data.value});

   function automatic logic [31:0] to32(input logic [ELEM_WIDTH-1:0] x);
      return 32'({32'd0, x});
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         init_ff  <= '0;
         func_ff  <= FN_QUERY;
         bef_ff   <= FRONT;
         aft_ff   <= BACK;
         cur_ff   <= '0;
         cnt_ff   <= '0;
         free_ff  <= CW'(CAPACITY);
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         func_ff  <= func_in;
         bef_ff   <= bef_in;
         aft_ff   <= aft_in;
         cur_ff   <= cur_in;
         cnt_ff   <= cnt_in;
         free_ff  <= free_in;
         rsp_valid <= done;
      end
      val_ff  <= val_in;
      new_ff  <= new_in;
      step_ff <= step_in;
      elem_ff <= elem_in;
      st_ff   <= st_in;
   end

   assign rsp_data.element = elem_ff;
   assign rsp_data.cursor_position = 9'(cur_ff);
   assign rsp_data.list_length = 9'(cnt_ff);
   assign rsp_data.status = st_ff;
   assign busy = state_ff != S_IDLE;

   always_comb begin
      state_in = state_ff; init_in = init_ff; func_in = func_ff; val_in = val_ff;
      bef_in = bef_ff; aft_in = aft_ff; new_in = new_ff; cur_in = cur_ff;
      cnt_in = cnt_ff; free_in = free_ff; step_in = step_ff;
      elem_in = elem_ff; st_in = st_ff; done = 1'b0;
      v_we = 1'b0; v_wa = aft_ff; v_wd = val_ff; v_ra = aft_ff;
      n_we = 1'b0; n_wa = init_ff; n_wd = BACK; n_ra = aft_ff;
      p_we = 1'b0; p_wa = init_ff; p_wd = FRONT; p_ra = bef_ff;
      f_we = 1'b0; f_wa = FW'(init_ff); f_wd = init_ff;
      f_ra = FW'(free_ff - CW'(1));
      case (state_ff)
         S_INIT: begin
            // rebuild free stack bottom-up: slot i holds CAPACITY-1-i
            f_we = init_ff < NW'(CAPACITY);
            f_wa = FW'(init_ff);
            f_wd = NW'(CAPACITY - 1) - init_ff;
            n_we = init_ff >= NW'(CAPACITY);
            n_wa = init_ff; n_wd = BACK;
            p_we = init_ff >= NW'(CAPACITY);
            p_wa = init_ff; p_wd = FRONT;
            if (init_ff == BACK) begin
               state_in = S_IDLE;
               if (func_ff == FN_CLEAR) done = 1'b1;
            end else init_in = init_ff + NW'(1);
         end
         S_IDLE: begin
            func_in = req_data.func; val_in = v_ext;
            st_in = ST_OK; elem_in = '0; step_in = '0;
            if (start) begin
               state_in = S_READ;
               // address reads for execute step
               case (req_data.func)
                  FN_FRONT, FN_READ_FRONT: n_ra = FRONT;
                  FN_BACK, FN_READ_BACK: p_ra = BACK;
                  default: begin n_ra = aft_ff; p_ra = bef_ff; end
               endcase
               v_ra = aft_ff;
               if (req_data.func == FN_PREV || req_data.func == FN_PEEK_PREV ||
                   req_data.func == FN_SET_BEFORE || req_data.func == FN_FIND_PREV)
                  v_ra = bef_ff;
               if (req_data.func == FN_CLEAR) begin
                  state_in = S_INIT; init_in = '0;
                  bef_in = FRONT; aft_in = BACK; cur_in = '0; cnt_in = '0;
                  free_in = CW'(CAPACITY);
               end
            end
         end
         S_READ: begin
            // n_rd/p_rd/v_rd/f_rd valid now
            state_in = S_IDLE; done = 1'b1;
            case (func_ff)
               FN_FRONT: begin cur_in = '0; bef_in = FRONT; aft_in = n_rd; end
               FN_BACK: begin cur_in = cnt_ff; aft_in = BACK; bef_in = p_rd; end
               FN_NEXT, FN_PEEK_NEXT: begin
                  if (at_back) st_in = ST_AT_BACK;
                  else begin
                     elem_in = to32(v_rd);
                     if (func_ff == FN_NEXT) begin
                        cur_in = cur_ff + CW'(1); bef_in = aft_ff; aft_in = n_rd;
                     end
                  end
               end
               FN_PREV, FN_PEEK_PREV: begin
                  if (at_front) st_in = ST_AT_FRONT;
                  else begin
                     elem_in = to32(v_rd);
                     if (func_ff == FN_PREV) begin
                        cur_in = cur_ff - CW'(1); aft_in = bef_ff; bef_in = p_rd;
                     end
                  end
               end
               FN_SET_AFTER: begin
                  if (at_back) st_in = ST_AT_BACK;
                  else begin v_we = 1'b1; v_wa = aft_ff; end
               end
               FN_SET_BEFORE: begin
                  if (at_front) st_in = ST_AT_FRONT;
                  else begin v_we = 1'b1; v_wa = bef_ff; end
               end
               FN_READ_FRONT, FN_READ_BACK: begin
                  if (cnt_ff == '0) st_in = ST_EMPTY;
                  else begin
                     // value read completes in S_EXEC
                     done = 1'b0; state_in = S_EXEC;
                     v_ra = (func_ff == FN_READ_FRONT) ? n_rd : p_rd;
                  end
               end
               FN_INS_AFTER, FN_INS_BEFORE: begin
                  if (free_ff == '0) st_in = ST_FULL;
                  else begin
                     done = 1'b0; state_in = S_EXEC; new_in = f_rd;
                     free_in = free_ff - CW'(1); cnt_in = cnt_ff + CW'(1);
                     v_we = 1'b1; v_wa = f_rd;
                     n_we = 1'b1; n_wa = f_rd; n_wd = aft_ff;
                     p_we = 1'b1; p_wa = f_rd; p_wd = bef_ff;
                  end
               end
               FN_ERASE_AFTER: begin
                  if (at_back) st_in = ST_AT_BACK;
                  else begin
                     done = 1'b0; state_in = S_EXEC;
                     f_we = 1'b1; f_wa = FW'(free_ff); f_wd = aft_ff;
                     free_in = free_ff + CW'(1); cnt_in = cnt_ff - CW'(1);
                     aft_in = n_rd;
                     n_we = 1'b1; n_wa = bef_ff; n_wd = n_rd;
                  end
               end
               FN_ERASE_BEFORE: begin
                  if (at_front) st_in = ST_AT_FRONT;
                  else begin
                     done = 1'b0; state_in = S_EXEC;
                     f_we = 1'b1; f_wa = FW'(free_ff); f_wd = bef_ff;
                     free_in = free_ff + CW'(1); cnt_in = cnt_ff - CW'(1);
                     cur_in = cur_ff - CW'(1);
                     bef_in = p_rd;
                     p_we = 1'b1; p_wa = aft_ff; p_wd = p_rd;
                  end
               end
               FN_FIND_NEXT, FN_FIND_PREV: begin
                  done = 1'b0; state_in = S_WALK; st_in = ST_NOT_FOUND;
               end
               default: ;
            endcase
         end
         S_EXEC: begin
            state_in = S_IDLE; done = 1'b1;
            case (func_ff)
               FN_READ_FRONT, FN_READ_BACK: elem_in = to32(v_rd);
               FN_INS_AFTER: begin
                  p_we = 1'b1; p_wa = aft_ff; p_wd = new_ff;
                  n_we = 1'b1; n_wa = bef_ff; n_wd = new_ff;
                  aft_in = new_ff;
               end
               FN_INS_BEFORE: begin
                  p_we = 1'b1; p_wa = aft_ff; p_wd = new_ff;
                  n_we = 1'b1; n_wa = bef_ff; n_wd = new_ff;
                  bef_in = new_ff; cur_in = cur_ff + CW'(1);
               end
               FN_ERASE_AFTER: begin p_we = 1'b1; p_wa = aft_ff; p_wd = bef_ff; end
               FN_ERASE_BEFORE: begin n_we = 1'b1; n_wa = bef_ff; n_wd = aft_ff; end
               default: ;
            endcase
         end
         S_WALK: begin
            // step_ff 0: issue reads; 1: compare and advance
            if (step_ff == 3'd0) begin
               if ((func_ff == FN_FIND_NEXT) ? at_back : at_front) begin
                  state_in = S_IDLE; done = 1'b1;
               end else begin
                  step_in = 3'd1;
                  v_ra = (func_ff == FN_FIND_NEXT) ? aft_ff : bef_ff;
                  n_ra = aft_ff; p_ra = bef_ff;
               end
            end else begin
               step_in = 3'd0;
               if (func_ff == FN_FIND_NEXT) begin
                  cur_in = cur_ff + CW'(1); bef_in = aft_ff; aft_in = n_rd;
               end else begin
                  cur_in = cur_ff - CW'(1); aft_in = bef_ff; bef_in = p_rd;
               end
               if (v_rd == val_ff) begin
                  st_in = ST_OK; elem_in = to32(v_rd);
                  state_in = S_IDLE; done = 1'b1;
               end
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   `CLL_ASSERT_IMPL(a_cur_in_range, clock, reset, 1'b1, cur_ff <= cnt_ff, "cursor past length")
   `CLL_ASSERT_IMPL(a_count_sum, clock, reset, state_ff == S_IDLE,
      (cnt_ff + free_ff) == CW'(CAPACITY), "count and free mismatch")
   `CLL_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "no busy after start")
endmodule
